// ===== hw/rtl/bmtr_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap text rasterizer package
// Shared widths, reset values, register indexes and the configuration
// struct used by the rasterizer top level and its scan engine.
// ----------------------------------------------------------------------------
package bmtr_pkg;

    // Default geometry of the glyph store.
    localparam int GLYPH_W_DEF    = 8;
    localparam int GLYPH_H_DEF    = 8;
    localparam int CODE_COUNT_DEF = 256;

    // Field and register widths.
    localparam int CODE_W     = 8;
    localparam int ROWSEL_W   = 3;
    localparam int ROWBITS_W  = 8;
    localparam int COORD_W    = 12;
    localparam int ORIGIN_W   = 13;
    localparam int BSIZE_W    = 5;
    localparam int COLOR_W    = 32;
    localparam int CANVAS_W   = 13;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Signed width of a block position; it never wraps for any setting.
    localparam int PX_W = 20;

    // Largest canvas dimension that takes part in clipping.
    localparam logic [CANVAS_W-1:0] CANVAS_LIMIT = 13'd4096;

    // Saturation value of the character position counter.
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST    = 5'd1;
    localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RST  = 13'd640;
    localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RST = 13'd480;

    // Command codes of an input item.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Configuration seen by the scan engine.
    typedef struct packed {
        logic signed [ORIGIN_W-1:0] origin_x;
        logic signed [ORIGIN_W-1:0] origin_y;
        logic [BSIZE_W-1:0]         block_size;
        logic [COLOR_W-1:0]         fill_color;
        logic [CANVAS_W-1:0]        canvas_width;
        logic [CANVAS_W-1:0]        canvas_height;
    } cfg_t;

    // End of a draw, reported back to the position counter.
    typedef struct packed {
        logic done;
        logic last;
    } draw_done_t;

endpackage

// ===== hw/rtl/bmtr_if.sv =====
// ----------------------------------------------------------------------------
// Bitmap text rasterizer channels
// Valid/ready channels for character items in and block items out.
// ----------------------------------------------------------------------------
interface bmtr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_code;
    logic [2:0] glyph_row;
    logic [7:0] row_bits;
    logic       last_char;

    modport source (output valid, command, char_code, glyph_row, row_bits, last_char,
                    input ready);
    modport sink (input valid, command, char_code, glyph_row, row_bits, last_char,
                  output ready);
endinterface

interface bmtr_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] block_x;
    logic [11:0] block_y;
    logic [31:0] block_color;
    logic        last_block;

    modport source (output valid, block_x, block_y, block_color, last_block,
                    input ready);
    modport sink (input valid, block_x, block_y, block_color, last_block,
                  output ready);
endinterface

// ===== hw/rtl/bitmap_text_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Bitmap text rasterizer
// Turns a string of character codes into scaled pixel blocks from a
// stored monochrome font.
// ----------------------------------------------------------------------------
// A load item (command 0) writes one glyph row into the font store, and the
// engine stays ready for the next item. A draw item (command 1) holds off the
// next item while the engine passes through its READ, SCAN and FLUSH states:
// the scan engine walks the glyph one pixel per cycle while the block consumer
// does not stall it, reading each glyph row from the synchronous font memory
// ahead of the scan, and emits at most one block per cycle. A draw of a code
// at or above CODE_COUNT skips the scan and emits nothing. Every block is the
// top-left corner of a block_size square; the last block of a character
// carries last_block. Glyph rows must be loaded before they are drawn; the
// store is not cleared at reset. The user must write configuration only while
// no draw is in progress and all blocks have been taken; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bitmap_text_rasterizer
    import bmtr_pkg::*;
#(
    parameter int GLYPH_W    = GLYPH_W_DEF,
    parameter int GLYPH_H    = GLYPH_H_DEF,
    parameter int CODE_COUNT = CODE_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    bmtr_in_if.sink               char_in,
    bmtr_out_if.source            block_out
);

    cfg_t             cfg_reg, cfg_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    draw_done_t       draw_done;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:      cfg_next.origin_x      = $signed(cfg_wdata[ORIGIN_W-1:0]);
                CFG_ORIGIN_Y:      cfg_next.origin_y      = $signed(cfg_wdata[ORIGIN_W-1:0]);
                CFG_BLOCK_SIZE:    cfg_next.block_size    = cfg_wdata[BSIZE_W-1:0];
                CFG_FILL_COLOR:    cfg_next.fill_color    = cfg_wdata[COLOR_W-1:0];
                CFG_CANVAS_WIDTH:  cfg_next.canvas_width  = cfg_wdata[CANVAS_W-1:0];
                CFG_CANVAS_HEIGHT: cfg_next.canvas_height = cfg_wdata[CANVAS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Character position: cleared after the last character, saturating otherwise.
    always_comb
    begin
        pos_next = pos_reg;
        if (draw_done.done)
        begin
            if (draw_done.last)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.block_size    <= BLOCK_SIZE_RST;
            cfg_reg.fill_color    <= '0;
            cfg_reg.canvas_width  <= CANVAS_WIDTH_RST;
            cfg_reg.canvas_height <= CANVAS_HEIGHT_RST;
            pos_reg               <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            pos_reg <= pos_next;
        end
    end

    // Font store and pixel scan.
    bmtr_engine #(
        .GLYPH_W    (GLYPH_W),
        .GLYPH_H    (GLYPH_H),
        .CODE_COUNT (CODE_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .char_pos  (pos_reg),
        .draw_done (draw_done),
        .char_in   (char_in),
        .block_out (block_out)
    );

endmodule

// ===== hw/rtl/bmtr_engine.sv =====
// ----------------------------------------------------------------------------
// Bitmap text rasterizer scan engine
// Holds the glyph store, walks one glyph pixel per cycle unless the block
// output stalls it, and emits the corners of the blocks that fall inside the canvas.
// ----------------------------------------------------------------------------
module bmtr_engine
    import bmtr_pkg::*;
#(
    parameter int GLYPH_W    = GLYPH_W_DEF,
    parameter int GLYPH_H    = GLYPH_H_DEF,
    parameter int CODE_COUNT = CODE_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic [POS_W-1:0]   char_pos,
    output draw_done_t         draw_done,
    bmtr_in_if.sink            char_in,
    bmtr_out_if.source         block_out
);

    localparam int DEPTH  = CODE_COUNT * GLYPH_H;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
    localparam int ROW_W  = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
    localparam int BASE_W = POS_W + COL_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [ROWBITS_W-1:0] glyph_mem [DEPTH];
    logic [ROWBITS_W-1:0] rd_data_reg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;

    logic [ADDR_W-1:0]    code_base_reg, code_base_next;
    logic                 last_reg, last_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic signed [PX_W-1:0] px_row0_reg, px_row0_next;
    logic signed [PX_W-1:0] px_reg, px_next;
    logic signed [PX_W-1:0] py_reg, py_next;

    logic                 hold_valid_reg, hold_valid_next;
    logic [COORD_W-1:0]   hold_x_reg, hold_x_next;
    logic [COORD_W-1:0]   hold_y_reg, hold_y_next;

    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   out_x_reg, out_x_next;
    logic [COORD_W-1:0]   out_y_reg, out_y_next;
    logic                 out_last_reg, out_last_next;

    logic                 in_xfer;
    logic                 code_ok;
    logic                 row_ok;
    logic [CANVAS_W-1:0]  cw_clip;
    logic [CANVAS_W-1:0]  ch_clip;
    logic signed [PX_W-1:0] bs_s;
    logic [BASE_W-1:0]    base_units;
    logic signed [PX_W-1:0] px_start;
    logic                 pixel_on;
    logic                 in_canvas;
    logic                 hit;
    logic                 out_free;
    logic                 scan_adv;
    logic                 last_col;
    logic                 last_row;
    logic                 move_out;
    logic                 flush_done;

    // Input handshake and range checks on the item fields.
    assign char_in.ready = (state_reg == ST_IDLE);
    assign in_xfer       = char_in.valid && char_in.ready;
    assign code_ok       = (32'(char_in.char_code) < CODE_COUNT);
    assign row_ok        = (32'(char_in.glyph_row) < GLYPH_H);

    // Glyph store: one write port for loads, one registered read port.
    assign wr_en   = in_xfer && (char_in.command == CMD_LOAD) && code_ok && row_ok;
    assign wr_addr = ADDR_W'(32'(char_in.char_code) * GLYPH_H + 32'(char_in.glyph_row));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            glyph_mem[wr_addr] <= char_in.row_bits;
        end
        if (rd_en)
        begin
            rd_data_reg <= glyph_mem[rd_addr];
        end
    end

    // Canvas clipping limits and scaled positions.
    assign cw_clip    = (cfg.canvas_width > CANVAS_LIMIT) ? CANVAS_LIMIT : cfg.canvas_width;
    assign ch_clip    = (cfg.canvas_height > CANVAS_LIMIT) ? CANVAS_LIMIT : cfg.canvas_height;
    assign bs_s       = $signed(PX_W'(cfg.block_size));
    assign base_units = BASE_W'(32'(char_pos) * GLYPH_W);
    assign px_start   = PX_W'(cfg.origin_x) + $signed(PX_W'(base_units * cfg.block_size));

    // Pixel test for the current glyph column.
    assign pixel_on  = rd_data_reg[col_reg];
    assign in_canvas = (px_reg >= 0) && (px_reg < $signed(PX_W'(cw_clip)))
                    && (py_reg >= 0) && (py_reg < $signed(PX_W'(ch_clip)));
    assign hit       = (state_reg == ST_SCAN) && pixel_on && in_canvas;
    assign out_free  = !out_valid_reg || block_out.ready;
    assign scan_adv  = (state_reg == ST_SCAN) && !(hit && hold_valid_reg && !out_free);
    assign last_col  = (col_reg == COL_W'(GLYPH_W - 1));
    assign last_row  = (row_reg == ROW_W'(GLYPH_H - 1));

    // The first row is read from the READ state, later rows ahead of the scan.
    assign rd_en   = (state_reg == ST_READ) || (scan_adv && last_col && !last_row);
    assign rd_addr = (state_reg == ST_READ) ? code_base_reg
                   : code_base_reg + ADDR_W'(row_reg) + ADDR_W'(1);

    // A block waits in the hold register until the next one proves it is not last.
    assign move_out   = (scan_adv && hit && hold_valid_reg)
                     || ((state_reg == ST_FLUSH) && hold_valid_reg && out_free);
    assign flush_done = (state_reg == ST_FLUSH) && (!hold_valid_reg || out_free);

    assign draw_done.done = flush_done;
    assign draw_done.last = last_reg;

    // Sequencer and scan counters.
    always_comb
    begin
        state_next      = state_reg;
        code_base_next  = code_base_reg;
        last_next       = last_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        px_row0_next    = px_row0_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        hold_valid_next = hold_valid_reg;
        hold_x_next     = hold_x_reg;
        hold_y_next     = hold_y_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (char_in.command == CMD_DRAW))
                begin
                    code_base_next = ADDR_W'(32'(char_in.char_code) * GLYPH_H);
                    last_next      = char_in.last_char;
                    state_next     = code_ok ? ST_READ : ST_FLUSH;
                end
            end
            ST_READ:
            begin
                px_row0_next = px_start;
                px_next      = px_start;
                py_next      = PX_W'(cfg.origin_y);
                row_next     = '0;
                col_next     = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_adv)
                begin
                    if (hit)
                    begin
                        hold_valid_next = 1'b1;
                        hold_x_next     = px_reg[COORD_W-1:0];
                        hold_y_next     = py_reg[COORD_W-1:0];
                    end
                    if (last_col)
                    begin
                        col_next = '0;
                        px_next  = px_row0_reg;
                        py_next  = py_reg + bs_s;
                        row_next = row_reg + ROW_W'(1);
                        if (last_row)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                        px_next  = px_reg + bs_s;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (flush_done)
                begin
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        if (move_out)
        begin
            out_valid_next = 1'b1;
            out_x_next     = hold_x_reg;
            out_y_next     = hold_y_reg;
            out_last_next  = (state_reg == ST_FLUSH);
        end
        else if (block_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_base_reg <= code_base_next;
        last_reg      <= last_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        px_row0_reg   <= px_row0_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        hold_x_reg    <= hold_x_next;
        hold_y_reg    <= hold_y_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_last_reg  <= out_last_next;
    end

    assign block_out.valid       = out_valid_reg;
    assign block_out.block_x     = out_x_reg;
    assign block_out.block_y     = out_y_reg;
    assign block_out.block_color = cfg.fill_color;
    assign block_out.last_block  = out_last_reg;

    // No block is left in the hold register once the engine is idle.
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("hold register still full in idle");

    // Every result comes out of the hold register.
    a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(hold_valid_reg))
        else $error("result emitted without a held block");

    // Scan counters stay inside the glyph.
    a_scan_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |->
            (col_reg <= COL_W'(GLYPH_W - 1)) && (row_reg <= ROW_W'(GLYPH_H - 1)))
        else $error("scan counter beyond glyph");

    // The block released at the end of a character is marked last.
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FLUSH) && hold_valid_reg && out_free) |=>
            (out_valid_reg && out_last_reg))
        else $error("final block of a character not marked last");

endmodule
